// ===== hdl/voxel_face_culling_mesher_unit_defines.svh =====
// Assertion macros used by the checker of the voxel face culling mesher.
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFCM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vfcm check failed");

// The consequent must hold in the cycle after the antecedent.
`define VFCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vfcm check failed");

`endif

// ===== hdl/vfcm_pkg.sv =====
// Shared types and constants of the voxel face culling mesher.
package vfcm_pkg;

    localparam int MAX_X_DEF = 16;
    localparam int MAX_Y_DEF = 256;
    localparam int MAX_Z_DEF = 16;

    localparam int PX_W   = 4;
    localparam int PY_W   = 8;
    localparam int PZ_W   = 4;
    localparam int SIDE_W = 3;
    localparam int TEX_W  = 4;
    localparam int NSIDES = 6;

    localparam int TEXS_W  = 24;
    localparam int SIZEX_W = 5;
    localparam int SIZEY_W = 9;
    localparam int SIZEZ_W = 5;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 24;

    localparam logic [TEXS_W-1:0]  TEX_RESET   = 24'h023333;
    localparam logic [SIZEX_W-1:0] SIZEX_RESET = 5'd16;
    localparam logic [SIZEY_W-1:0] SIZEY_RESET = 9'd256;
    localparam logic [SIZEZ_W-1:0] SIZEZ_RESET = 5'd16;

    localparam logic [CIDX_W-1:0] REG_TEXTURES = 2'd0;
    localparam logic [CIDX_W-1:0] REG_SIZE_X   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SIZE_Y   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SIZE_Z   = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_MESH  = 1'b1;

    localparam logic [SIDE_W-1:0] SIDE_PZ = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_MZ = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_PX = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_MX = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_MY = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_PY = 3'd5;

    typedef struct packed {
        logic [NSIDES-1:0] mask;
        logic [PX_W-1:0]   x;
        logic [PY_W-1:0]   y;
        logic [PZ_W-1:0]   z;
    } t_face_job;

endpackage

// ===== hdl/vfcm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module vfcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/vfcm_emit.sv =====
// Face emitter: walks the visible-side mask of one query and drives result beats.
module vfcm_emit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  vfcm_pkg::t_face_job              i_job,
    output logic                             o_job_ready,
    input  logic [vfcm_pkg::TEXS_W-1:0]      i_face_textures,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [vfcm_pkg::PX_W-1:0]        o_face_x,
    output logic [vfcm_pkg::PY_W-1:0]        o_face_y,
    output logic [vfcm_pkg::PZ_W-1:0]        o_face_z,
    output logic [vfcm_pkg::SIDE_W-1:0]      o_side,
    output logic [vfcm_pkg::TEX_W-1:0]       o_texture,
    output logic                             o_last
);

    logic [vfcm_pkg::NSIDES-1:0] r_mask;
    logic [vfcm_pkg::PX_W-1:0]   r_jx;
    logic [vfcm_pkg::PY_W-1:0]   r_jy;
    logic [vfcm_pkg::PZ_W-1:0]   r_jz;
    logic                        r_out_valid;
    logic [vfcm_pkg::PX_W-1:0]   r_face_x;
    logic [vfcm_pkg::PY_W-1:0]   r_face_y;
    logic [vfcm_pkg::PZ_W-1:0]   r_face_z;
    logic [vfcm_pkg::SIDE_W-1:0] r_side;
    logic [vfcm_pkg::TEX_W-1:0]  r_texture;
    logic                        r_last;

    logic [vfcm_pkg::SIDE_W-1:0] sel;
    logic                        found;
    logic [vfcm_pkg::NSIDES-1:0] n_mask_rest;
    logic                        out_free;
    logic                        have_face;

    always_comb begin
        sel   = vfcm_pkg::SIDE_PZ;
        found = 1'b0;
        for (int i = 0; i < vfcm_pkg::NSIDES; i++) begin
            if (r_mask[i] && !found) begin
                sel   = vfcm_pkg::SIDE_W'(i);
                found = 1'b1;
            end
        end
        n_mask_rest = r_mask & ~(vfcm_pkg::NSIDES'(1) << sel);
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign have_face   = (r_mask != '0);
    assign o_job_ready = !have_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!have_face) begin
                if (i_job_valid) begin
                    r_mask <= i_job.mask;
                end
            end else if (out_free) begin
                r_mask <= n_mask_rest;
            end
            if (out_free) begin
                r_out_valid <= have_face;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!have_face && i_job_valid) begin
            r_jx <= i_job.x;
            r_jy <= i_job.y;
            r_jz <= i_job.z;
        end
        if (out_free && have_face) begin
            r_face_x  <= r_jx;
            r_face_y  <= r_jy;
            r_face_z  <= r_jz;
            r_side    <= sel;
            r_texture <= i_face_textures[{sel, 2'b00} +: vfcm_pkg::TEX_W];
            r_last    <= (n_mask_rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_face_x    = r_face_x;
    assign o_face_y    = r_face_y;
    assign o_face_z    = r_face_z;
    assign o_side      = r_side;
    assign o_texture   = r_texture;
    assign o_last      = r_last;

endmodule

// ===== hdl/voxel_face_culling_mesher_unit.sv =====
// Top level of the voxel face culling mesher: sequencer, voxel store and emitter.
// After reset the block clears its voxel store, one row of MAX_Z voxels per cycle, all
// MAX_X * MAX_Y rows (4096 with the default sizes), while o_in_stall stays high; the
// configuration port takes writes throughout. The store is one RAM row per (x, y) column,
// so a write beat is accepted, reads its row and writes the row back, and a mesh beat is
// accepted, makes five row reads through the single RAM read port (the voxel's own row,
// which also serves both z neighbors, then the x and y neighbors) and hands the visible
// side mask to the emitter. The emitter then delivers up to six face beats, one per cycle
// unless stalled, while the next beat is already being worked on. The hand-off of a mesh
// beat waits only while stalled face beats keep the emitter busy with the previous query.
module voxel_face_culling_mesher_unit #(
    parameter int MAX_X = vfcm_pkg::MAX_X_DEF,
    parameter int MAX_Y = vfcm_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vfcm_pkg::MAX_Z_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [vfcm_pkg::PX_W-1:0]       i_pos_x,
    input  logic [vfcm_pkg::PY_W-1:0]       i_pos_y,
    input  logic [vfcm_pkg::PZ_W-1:0]       i_pos_z,
    input  logic                            i_solid,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [vfcm_pkg::PX_W-1:0]       o_face_x,
    output logic [vfcm_pkg::PY_W-1:0]       o_face_y,
    output logic [vfcm_pkg::PZ_W-1:0]       o_face_z,
    output logic [vfcm_pkg::SIDE_W-1:0]     o_side,
    output logic [vfcm_pkg::TEX_W-1:0]      o_texture,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vfcm_pkg::CIDX_W-1:0]     i_cfg_index,
    input  logic [vfcm_pkg::CDAT_W-1:0]     i_cfg_data
);

    localparam int ROWS = MAX_X * MAX_Y;
    localparam int AW   = $clog2(ROWS);
    localparam int ZW   = $clog2(MAX_Z);
    localparam int LW   = 11;

    localparam logic [AW-1:0] Y_ROWS   = AW'(MAX_Y);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);
    localparam logic [LW-1:0] LIM_X    = LW'(MAX_X);
    localparam logic [LW-1:0] LIM_Y    = LW'(MAX_Y);
    localparam logic [LW-1:0] LIM_Z    = LW'(MAX_Z);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WR_RD = 3'd2;
    localparam logic [2:0] ST_WR_WB = 3'd3;
    localparam logic [2:0] ST_Q_RD  = 3'd4;
    localparam logic [2:0] ST_HAND  = 3'd5;

    localparam logic [2:0] STEP_C  = 3'd0;
    localparam logic [2:0] STEP_XP = 3'd1;
    localparam logic [2:0] STEP_XM = 3'd2;
    localparam logic [2:0] STEP_YM = 3'd3;
    localparam logic [2:0] STEP_YP = 3'd4;
    localparam logic [2:0] STEP_END = 3'd5;

    logic [2:0]                      r_state;
    logic [AW-1:0]                   r_clr;
    logic [2:0]                      r_step;
    logic [vfcm_pkg::PX_W-1:0]       r_x;
    logic [vfcm_pkg::PY_W-1:0]       r_y;
    logic [vfcm_pkg::PZ_W-1:0]       r_z;
    logic                            r_wval;
    logic                            r_solid;
    logic [vfcm_pkg::NSIDES-1:0]     r_mask;
    logic [vfcm_pkg::TEXS_W-1:0]     r_tex;
    logic [vfcm_pkg::SIZEX_W-1:0]    r_size_x;
    logic [vfcm_pkg::SIZEY_W-1:0]    r_size_y;
    logic [vfcm_pkg::SIZEZ_W-1:0]    r_size_z;

    logic [vfcm_pkg::SIZEX_W-1:0]    e_x;
    logic [vfcm_pkg::SIZEY_W-1:0]    e_y;
    logic [vfcm_pkg::SIZEZ_W-1:0]    e_z;
    logic                            in_center;
    logic                            in_zp;
    logic                            in_zm;
    logic                            in_xp;
    logic                            in_xm;
    logic                            in_ym;
    logic                            in_yp;
    logic [vfcm_pkg::SIZEX_W-1:0]    rd_x;
    logic [vfcm_pkg::SIZEY_W-1:0]    rd_y;
    logic [AW-1:0]                   row_addr;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [MAX_Z-1:0]                ram_wdata;
    logic                            ram_re;
    logic [MAX_Z-1:0]                ram_q;
    logic [ZW-1:0]                   zi;
    logic [ZW-1:0]                   zp_i;
    logic [ZW-1:0]                   zm_i;
    logic                            job_valid;
    vfcm_pkg::t_face_job             job;
    logic                            job_ready;

    always_comb begin
        e_x = (LW'(r_size_x) > LIM_X) ? vfcm_pkg::SIZEX_W'(LIM_X) : r_size_x;
        e_y = (LW'(r_size_y) > LIM_Y) ? vfcm_pkg::SIZEY_W'(LIM_Y) : r_size_y;
        e_z = (LW'(r_size_z) > LIM_Z) ? vfcm_pkg::SIZEZ_W'(LIM_Z) : r_size_z;
    end

    assign in_center = (vfcm_pkg::SIZEX_W'(i_pos_x) < e_x)
                    && (vfcm_pkg::SIZEY_W'(i_pos_y) < e_y)
                    && (vfcm_pkg::SIZEZ_W'(i_pos_z) < e_z);

    assign in_zp = (vfcm_pkg::SIZEZ_W'(r_z) + 5'd1) < e_z;
    assign in_zm = (r_z != '0);
    assign in_xp = (vfcm_pkg::SIZEX_W'(r_x) + 5'd1) < e_x;
    assign in_xm = (r_x != '0);
    assign in_ym = (r_y != '0);
    assign in_yp = (vfcm_pkg::SIZEY_W'(r_y) + 9'd1) < e_y;

    assign zi   = ZW'(r_z);
    assign zp_i = ZW'(vfcm_pkg::SIZEZ_W'(r_z) + 5'd1);
    assign zm_i = ZW'(vfcm_pkg::SIZEZ_W'(r_z) - 5'd1);

    always_comb begin
        rd_x = vfcm_pkg::SIZEX_W'(r_x);
        rd_y = vfcm_pkg::SIZEY_W'(r_y);
        if (r_state == ST_Q_RD) begin
            case (r_step)
                STEP_XP: rd_x = vfcm_pkg::SIZEX_W'(r_x) + 5'd1;
                STEP_XM: rd_x = vfcm_pkg::SIZEX_W'(r_x) - 5'd1;
                STEP_YM: rd_y = vfcm_pkg::SIZEY_W'(r_y) - 9'd1;
                STEP_YP: rd_y = vfcm_pkg::SIZEY_W'(r_y) + 9'd1;
                default: ;
            endcase
        end
    end

    assign row_addr = AW'(rd_x) * Y_ROWS + AW'(rd_y);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = row_addr;
        ram_wdata = ram_q;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == ST_WR_WB) begin
            ram_we        = 1'b1;
            ram_wdata[zi] = r_wval;
        end
    end

    assign ram_re = (r_state == ST_WR_RD) || ((r_state == ST_Q_RD) && (r_step != STEP_END));

    vfcm_ram #(
        .WIDTH (MAX_Z),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (row_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_step   <= STEP_C;
            r_tex    <= vfcm_pkg::TEX_RESET;
            r_size_x <= vfcm_pkg::SIZEX_RESET;
            r_size_y <= vfcm_pkg::SIZEY_RESET;
            r_size_z <= vfcm_pkg::SIZEZ_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vfcm_pkg::REG_TEXTURES: r_tex <= i_cfg_data[vfcm_pkg::TEXS_W-1:0];
                    vfcm_pkg::REG_SIZE_X:   r_size_x <= i_cfg_data[vfcm_pkg::SIZEX_W-1:0];
                    vfcm_pkg::REG_SIZE_Y:   r_size_y <= i_cfg_data[vfcm_pkg::SIZEY_W-1:0];
                    vfcm_pkg::REG_SIZE_Z:   r_size_z <= i_cfg_data[vfcm_pkg::SIZEZ_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ROW) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid && in_center) begin
                        r_step  <= STEP_C;
                        r_state <= (i_kind == vfcm_pkg::KIND_WRITE) ? ST_WR_RD : ST_Q_RD;
                    end
                end
                ST_WR_RD: r_state <= ST_WR_WB;
                ST_WR_WB: r_state <= ST_IDLE;
                ST_Q_RD: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == STEP_END) begin
                        r_state <= ST_HAND;
                    end
                end
                ST_HAND: begin
                    if (job_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_wval <= i_solid;
        end
        if (r_state == ST_Q_RD) begin
            case (r_step)
                STEP_XP: begin
                    r_solid   <= ram_q[zi];
                    r_mask[0] <= !in_zp || !ram_q[zp_i];
                    r_mask[1] <= !in_zm || !ram_q[zm_i];
                end
                STEP_XM:  r_mask[2] <= !in_xp || !ram_q[zi];
                STEP_YM:  r_mask[3] <= !in_xm || !ram_q[zi];
                STEP_YP:  r_mask[4] <= !in_ym || !ram_q[zi];
                STEP_END: r_mask[5] <= !in_yp || !ram_q[zi];
                default: ;
            endcase
        end
    end

    assign job_valid = (r_state == ST_HAND);
    assign job.mask  = r_mask & {vfcm_pkg::NSIDES{r_solid}};
    assign job.x     = r_x;
    assign job.y     = r_y;
    assign job.z     = r_z;

    vfcm_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_ready     (job_ready),
        .i_face_textures (r_tex),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_face_x        (o_face_x),
        .o_face_y        (o_face_y),
        .o_face_z        (o_face_z),
        .o_side          (o_side),
        .o_texture       (o_texture),
        .o_last          (o_last)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hdl/vfcm_checker.sv =====
// Port-level checker for the voxel face culling mesher, bound to the top level.
`include "voxel_face_culling_mesher_unit_defines.svh"

module vfcm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [vfcm_pkg::PX_W-1:0]       o_face_x,
    input logic [vfcm_pkg::PY_W-1:0]       o_face_y,
    input logic [vfcm_pkg::PZ_W-1:0]       o_face_z,
    input logic [vfcm_pkg::SIDE_W-1:0]     o_side,
    input logic [vfcm_pkg::TEX_W-1:0]      o_texture,
    input logic                            o_last
);

    `VFCM_ASSERT_NEXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_face_x) && $stable(o_face_y) && $stable(o_face_z) && $stable(o_side) && $stable(o_texture) && $stable(o_last))
    `VFCM_ASSERT_SAME(a_side_range, o_out_valid, o_side <= vfcm_pkg::SIDE_PY)
    `VFCM_ASSERT_SAME(a_top_is_last, o_out_valid && (o_side == vfcm_pkg::SIDE_PY), o_last)

endmodule

bind voxel_face_culling_mesher_unit vfcm_checker u_vfcm_checker (.*);
